// File: src/lsc_pkg.sv
// Shared constants and exponential step table of the layer stack compositor.
// No dependencies.
`default_nettype none
package lsc_pkg;
   localparam logic [2:0] MODE_MEAN  = 3'd0;
   localparam logic [2:0] MODE_MAX   = 3'd1;
   localparam logic [2:0] MODE_MIN   = 3'd2;
   localparam logic [2:0] MODE_ALPHA = 3'd3;
   localparam logic [2:0] MODE_BEER  = 3'd4;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_LOW  = 3'd1;
   localparam logic [2:0] REG_HIGH = 3'd2;
   localparam logic [2:0] REG_STOP = 3'd3;
   localparam logic [2:0] REG_GAIN = 3'd4;
   localparam logic [2:0] REG_ABS  = 3'd5;
   localparam logic [2:0] REG_EMIT = 3'd6;
   localparam logic [2:0] REG_AMB  = 3'd7;

   localparam logic [16:0] FULL_Q16  = 17'd65536;
   localparam logic [15:0] TOP_Q88   = 16'd65280;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [16:0] STOP_T    = 17'd66;

   function automatic logic [15:0] exp_entry(input logic [3:0] k);
      logic [15:0] r;
      begin
         unique case (k)
            4'd0: r = 16'd46341;  4'd1: r = 16'd55109;
            4'd2: r = 16'd60097;  4'd3: r = 16'd62757;
            4'd4: r = 16'd64132;  4'd5: r = 16'd64830;
            4'd6: r = 16'd65181;  4'd7: r = 16'd65359;
            4'd8: r = 16'd65447;  4'd9: r = 16'd65492;
            4'd10: r = 16'd65514; 4'd11: r = 16'd65525;
            4'd12: r = 16'd65530; 4'd13: r = 16'd65533;
            default: r = 16'd65535;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// File: src/lsc_if.sv
// Valid/ready channel interfaces for layer beats and result beats.
// No dependencies.
`default_nettype none
interface lsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] layer_value;
   logic       last_layer;
   logic       empty_stack;
   modport source (output valid, layer_value, last_layer, empty_stack, input ready);
   modport sink   (input valid, layer_value, last_layer, empty_stack, output ready);
endinterface

interface lsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] composite;
   logic        bad_window;
   modport source (output valid, composite, bad_window, input ready);
   modport sink   (input valid, composite, bad_window, output ready);
endinterface
`default_nettype wire

// File: src/lsc_div.sv
// Restoring divider, one quotient bit per cycle: 48-bit dividend, 32-bit divisor.
// Depends on nothing.
`default_nettype none
module lsc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [47:0]      quotient
);
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; dvs_in = dvs_ff; done = 1'b0;
      trial = {rem_ff[31:0], quo_ff[47]};
      if (start) begin
         rem_in = '0; quo_in = dividend; cnt_in = 6'd0;
         busy_in = 1'b1; dvs_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[46:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   assign quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in;
   end
endmodule
`default_nettype wire

// File: src/layer_stack_compositor.sv
// Top level of the layer stack compositor: APB registers, sequencer,
// one shared 34x17 multiplier. Depends on lsc_pkg, lsc_if, lsc_div.
//
//   channel | dir | beat
//   req     | in  | layer_value, last_layer, empty_stack
//   rsp     | out | composite, bad_window
//   csr     | in  | APB write/read of eight registers, up to 16 bits wide
//
// Mean/max/min layers and skipped layers pass through S_FIN1 back to S_IDLE.
// Alpha layers run the divide in S_DIV, three multiplies and close. Beer-Lambert
// layers run three multiplies, 16 exponential steps, three more, close.
// A last layer passes through S_OUT before rsp is valid, a mean result also through
// its divide; an empty stack beat shows its result the next cycle. Reset is
// synchronous; req is not ready while a layer is in work or a result waits.
`default_nettype none
module layer_stack_compositor
   import lsc_pkg::*;
#(
   parameter int MAX_LAYERS = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lsc_req_if.sink    req,
   lsc_rsp_if.source  rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int CW = $clog2(MAX_LAYERS + 1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DIV   = 11'b00000000010,
      S_MUL1  = 11'b00000000100,
      S_MUL2  = 11'b00000001000,
      S_MUL3  = 11'b00000010000,
      S_MUL4  = 11'b00000100000,
      S_EXP   = 11'b00001000000,
      S_MUL5  = 11'b00010000000,
      S_FIN1  = 11'b00100000000,
      S_FIN2  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  mode_ff;
   logic [15:0] low_ff, high_ff, stop_ff, gain_ff, abs_ff, emit_ff, amb_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  ext_ff, ext_in;
   logic [16:0] cov_ff, cov_in;
   logic        stop_st_ff, stop_st_in;
   logic        last_ff, last_in;
   logic [33:0] a_ff, a_in;       // scratch operands
   logic [33:0] b_ff, b_in;
   logic [16:0] r_ff, r_in;
   logic [3:0]  k_ff, k_in;
   logic [15:0] f_ff, f_in;
   logic [5:0]  ip_ff, ip_in;
   logic        ov_ff, ov_in;
   logic [15:0] out_comp_ff, out_comp_in;
   logic        out_bad_ff, out_bad_in;
   logic        ovalid_ff, ovalid_in;

   // shared multiplier
   logic [33:0] mul_a;
   logic [16:0] mul_b;
   logic [50:0] prod;
   assign prod = mul_a * mul_b;

   logic        div_start, div_done;
   logic [47:0] div_n, div_q;
   logic [31:0] div_d;
   lsc_div u_div (.clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q));

   logic wr;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_MODE: csr_prdata = {29'd0, mode_ff};
         REG_LOW:  csr_prdata = {16'd0, low_ff};
         REG_HIGH: csr_prdata = {16'd0, high_ff};
         REG_STOP: csr_prdata = {16'd0, stop_ff};
         REG_GAIN: csr_prdata = {16'd0, gain_ff};
         REG_ABS:  csr_prdata = {16'd0, abs_ff};
         REG_EMIT: csr_prdata = {16'd0, emit_ff};
         default:  csr_prdata = {16'd0, amb_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MEAN; low_ff <= 16'd0; high_ff <= 16'hFFFF;
         stop_ff <= 16'hFFFF; gain_ff <= 16'd256; abs_ff <= 16'd256;
         emit_ff <= 16'd256; amb_ff <= 16'd0;
      end else if (wr) begin
         unique case (csr_paddr[4:2])
            REG_MODE: mode_ff <= csr_pwdata[2:0];
            REG_LOW:  low_ff  <= csr_pwdata[15:0];
            REG_HIGH: high_ff <= csr_pwdata[15:0];
            REG_STOP: stop_ff <= csr_pwdata[15:0];
            REG_GAIN: gain_ff <= csr_pwdata[15:0];
            REG_ABS:  abs_ff  <= csr_pwdata[15:0];
            REG_EMIT: emit_ff <= csr_pwdata[15:0];
            default:  amb_ff  <= csr_pwdata[15:0];
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.composite = out_comp_ff;
   assign rsp.bad_window = out_bad_ff;

   logic        take, bad_win;
   logic [16:0] hl;
   logic [23:0] low255;
   logic [16:0] d_beer;
   logic [16:0] opac;
   logic [41:0] sat255;
   logic [33:0] tot;
   assign take = req.valid && req.ready;
   assign bad_win = high_ff <= low_ff;
   assign hl = {1'b0, high_ff} - {1'b0, low_ff};
   assign low255 = {8'd0, low_ff} * 24'd255;
   // v*65536/255 rounded: 65536 = 255*257 + 1, so v*257 plus one when v >= 128
   assign d_beer = {1'b0, req.layer_value, req.layer_value} +
                   {16'd0, req.layer_value[7]};

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; acc_in = acc_ff; ext_in = ext_ff;
      cov_in = cov_ff; stop_st_in = stop_st_ff; last_in = last_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff; k_in = k_ff; f_in = f_ff;
      ip_in = ip_ff; ov_in = ov_ff;
      out_comp_in = out_comp_ff; out_bad_in = out_bad_ff; ovalid_in = ovalid_ff;
      mul_a = a_ff; mul_b = b_ff[16:0];
      div_start = 1'b0; div_n = '0; div_d = '0;
      opac = '0; sat255 = '0; tot = '0;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               last_in = req.last_layer;
               if (req.empty_stack) begin
                  cnt_in = '0; acc_in = '0; ext_in = '0; cov_in = FULL_Q16;
                  stop_st_in = 1'b0; out_comp_in = '0; out_bad_in = 1'b0;
                  ovalid_in = 1'b1;
               end else if (cnt_ff >= CW'(MAX_LAYERS)) begin
                  state_in = S_FIN1;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
                  unique case (mode_ff)
                     MODE_MAX: begin
                        if (cnt_ff == '0 || req.layer_value > ext_ff)
                           ext_in = req.layer_value;
                        state_in = S_FIN1;
                     end
                     MODE_MIN: begin
                        if (cnt_ff == '0 || req.layer_value < ext_ff)
                           ext_in = req.layer_value;
                        state_in = S_FIN1;
                     end
                     MODE_ALPHA: begin
                        // skip when window bad, stopped or numerator not positive
                        if (bad_win || stop_st_ff ||
                            {req.layer_value, 16'd0} <= low255)
                           state_in = S_FIN1;
                        else if (FULL_Q16 - cov_ff >= {1'b0, stop_ff}) begin
                           stop_st_in = 1'b1; state_in = S_FIN1;
                        end else begin
                           div_start = 1'b1;
                           div_n = {8'd0, {req.layer_value, 16'd0} - low255, 16'd0};
                           div_d = 32'({8'd0, hl} * 25'd255);
                           state_in = S_DIV;
                        end
                     end
                     MODE_BEER: begin
                        if (stop_st_ff || req.layer_value == 8'd0)
                           state_in = S_FIN1;
                        else begin
                           b_in = 34'(d_beer); // d
                           state_in = S_MUL1;
                        end
                     end
                     default: begin
                        acc_in = acc_ff + 32'(req.layer_value);
                        state_in = S_FIN1;
                     end
                  endcase
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (mode_ff == MODE_ALPHA) begin
                  b_in = (div_q > 48'(FULL_Q16)) ? 34'(FULL_Q16) : div_q[33:0]; // norm
                  state_in = S_MUL1;
               end else begin
                  // mean quotient
                  out_comp_in = (div_q > 48'(TOP_Q88)) ? TOP_Q88 : div_q[15:0];
                  out_bad_in = 1'b0;
                  state_in = S_OUT;
               end
            end
         end
         S_MUL1: begin
            if (mode_ff == MODE_ALPHA) begin
               mul_a = 34'(gain_ff); mul_b = b_ff[16:0];
               opac = (prod[50:8] > 43'(FULL_Q16)) ? FULL_Q16 : prod[24:8];
               a_in = 34'(opac);
            end else begin
               mul_a = 34'(abs_ff); mul_b = b_ff[16:0];
               a_in = 34'(prod[50:8]); // x
            end
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (mode_ff == MODE_ALPHA) begin
               mul_a = 34'(cov_ff); mul_b = a_ff[16:0];
               a_in = 34'(prod[50:16]); // w
            end else begin
               mul_a = a_ff; mul_b = LOG2E_Q16;
               f_in = prod[31:16];
               ov_in = |prod[50:38];
               ip_in = prod[37:32];
               r_in = FULL_Q16; k_in = '0;
            end
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (mode_ff == MODE_ALPHA) begin
               mul_a = a_ff; mul_b = b_ff[16:0];
               acc_in = acc_ff + 32'(prod[50:16]);
               cov_in = cov_ff - a_ff[16:0];
               state_in = S_FIN1;
            end else begin
               mul_a = 34'(emit_ff); mul_b = b_ff[16:0];
               b_in = 34'(prod[50:8]); // emission
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            mul_a = 34'(r_ff); mul_b = {1'b0, exp_entry(k_ff)};
            if (f_ff[15]) r_in = 17'((prod + 51'd32768) >> 16);
            f_in = {f_ff[14:0], 1'b0};
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd15) state_in = S_MUL4;
         end
         S_MUL4: begin
            // t = r >> ip, then emission*coverage
            if (ov_ff || ip_ff >= 6'd17) r_in = '0;
            else r_in = r_ff >> ip_ff;
            mul_a = b_ff; mul_b = cov_ff;
            a_in = 34'(prod[50:16]);
            state_in = S_MUL5;
         end
         S_MUL5: begin
            mul_a = a_ff; mul_b = FULL_Q16 - r_ff;
            tot = 34'(acc_ff) + 34'(prod[50:16]);
            acc_in = tot[33:32] != 2'd0 ? 32'hFFFF_FFFF : tot[31:0];
            state_in = S_FIN2;
         end
         S_FIN2: begin
            mul_a = 34'(cov_ff); mul_b = r_ff;
            cov_in = prod[32:16];
            if (prod[32:16] < STOP_T) stop_st_in = 1'b1;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            // end of layer: emit on last mark
            if (!last_ff) state_in = S_IDLE;
            else begin
               out_bad_in = 1'b0;
               state_in = S_OUT;
               unique case (mode_ff)
                  MODE_MAX, MODE_MIN: out_comp_in = {ext_ff, 8'd0};
                  MODE_ALPHA: begin
                     if (bad_win) begin
                        out_bad_in = 1'b1; out_comp_in = '0;
                     end else begin
                        sat255 = 42'(acc_ff) * 42'd255;
                        out_comp_in = sat255[41:8] > 34'(TOP_Q88) ? TOP_Q88
                                                                  : sat255[23:8];
                     end
                  end
                  MODE_BEER: begin
                     mul_a = 34'(amb_ff); mul_b = cov_ff;
                     tot = 34'(acc_ff) + 34'(prod[50:8]);
                     sat255 = 42'(tot) * 42'd255;
                     out_comp_in = sat255[41:8] > 34'(TOP_Q88) ? TOP_Q88
                                                               : sat255[23:8];
                  end
                  default: begin
                     div_start = 1'b1;
                     div_n = 48'(acc_ff) * 48'd256 + 48'(cnt_ff >> 1);
                     div_d = (cnt_ff == '0) ? 32'd1 : 32'(cnt_ff);
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_OUT: begin
            cnt_in = '0; acc_in = '0; ext_in = '0; cov_in = FULL_Q16;
            stop_st_in = 1'b0; ovalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; acc_ff <= '0; ext_ff <= '0;
         cov_ff <= FULL_Q16; stop_st_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; acc_ff <= acc_in; ext_ff <= ext_in;
         cov_ff <= cov_in; stop_st_ff <= stop_st_in; ovalid_ff <= ovalid_in;
      end
      last_ff <= last_in; a_ff <= a_in; b_ff <= b_in; r_ff <= r_in;
      k_ff <= k_in; f_ff <= f_in; ip_ff <= ip_in; ov_ff <= ov_in;
      out_comp_ff <= out_comp_in; out_bad_ff <= out_bad_in;
   end
endmodule
`default_nettype wire
